### src/soq_pkg.sv
// Package for the seat occupancy qualifier: item, result, configuration and state types.
// Also holds the register index codes and reset values. No dependencies.
package soq_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_AUTO_FLUSH_ENABLE   = 3'd0,
    CFG_ENERGY_SAVE_ALLOWED = 3'd1,
    CFG_ON_DEBOUNCE_TICKS   = 3'd2,
    CFG_LONG_SIT_TICKS      = 3'd3,
    CFG_OFF_DEBOUNCE_TICKS  = 3'd4,
    CFG_FLUSH_DELAY_TICKS   = 3'd5,
    CFG_DEODOR_OFF_TICKS    = 3'd6,
    CFG_ENERGY_DELAY_TICKS  = 3'd7
  } soq_cfg_index_t;

  localparam logic [9:0]  OnDebounceReset  = 10'd10;
  localparam logic [10:0] LongSitReset     = 11'd1000;
  localparam logic [15:0] OffDebounceReset = 16'd200;
  localparam logic [15:0] FlushDelayReset  = 16'd600;
  localparam logic [15:0] DeodorOffReset   = 16'd6000;
  localparam logic [15:0] EnergyDelayReset = 16'd60000;

  localparam logic [1:0] HistOccupied = 2'b01;
  localparam logic [1:0] HistLeft     = 2'b10;

  typedef struct packed {
    logic seat_present;
    logic test_mode;
  } soq_in_t;

  typedef struct packed {
    logic       seated;
    logic       present_confirmed;
    logic       sit_start;
    logic       absent_confirmed;
    logic       leave_event;
    logic       flush_request;
    logic       deodor_enable;
    logic       deodor_armed;
    logic       energy_save_request;
    logic [1:0] seat_history;
  } soq_out_t;

  typedef struct packed {
    logic        auto_flush_enable;
    logic        energy_save_allowed;
    logic [9:0]  on_debounce_ticks;
    logic [10:0] long_sit_ticks;
    logic [15:0] off_debounce_ticks;
    logic [15:0] flush_delay_ticks;
    logic [15:0] deodor_off_ticks;
    logic [15:0] energy_delay_ticks;
  } soq_cfg_t;

  typedef struct packed {
    logic [10:0] presence_count;
    logic [15:0] absence_count;
    logic        seated_flag;
    logic        long_sit_done;
    logic        flush_armed;
    logic        deodor_on;
    logic        deodor_ready;
    logic        energy_req;
    logic [1:0]  history_bits;
  } soq_state_t;

endpackage

### src/soq_step.sv
// Next-state and result logic for one tick of the seat occupancy qualifier.
// Purely combinational; uses the types of soq_pkg.
module soq_step (
  input  soq_pkg::soq_cfg_t   cfg,
  input  soq_pkg::soq_state_t state,
  input  soq_pkg::soq_in_t    item,
  output soq_pkg::soq_state_t state_next,
  output soq_pkg::soq_out_t   result
);
  import soq_pkg::*;

  logic [11:0] pres_inc;
  logic [16:0] abs_inc;

  assign pres_inc = {1'b0, state.presence_count} + 12'd1;
  assign abs_inc  = {1'b0, state.absence_count} + 17'd1;

  always_comb begin
    state_next = state;
    result     = '0;

    if (item.seat_present) begin
      state_next.absence_count  = '0;
      state_next.presence_count = pres_inc[10:0];
      if (pres_inc > {2'b00, cfg.on_debounce_ticks}) begin
        result.present_confirmed = 1'b1;
        state_next.deodor_on     = 1'b1;
        state_next.energy_req    = 1'b0;
        state_next.history_bits  = state.history_bits | HistOccupied;
        if (!state.seated_flag) begin
          state_next.seated_flag = 1'b1;
          result.sit_start       = 1'b1;
        end
        if (pres_inc > {1'b0, cfg.long_sit_ticks}) begin
          state_next.presence_count = cfg.long_sit_ticks;
          if (!state.long_sit_done) begin
            state_next.long_sit_done = 1'b1;
            if (cfg.auto_flush_enable) begin
              state_next.flush_armed = 1'b1;
            end
          end
        end
      end
    end else begin
      state_next.absence_count = abs_inc[15:0];
      if (abs_inc > {1'b0, cfg.off_debounce_ticks}) begin
        result.absent_confirmed   = 1'b1;
        state_next.presence_count = '0;
        state_next.deodor_ready   = 1'b1;
        state_next.history_bits   = state.history_bits | HistLeft;
        if (state.seated_flag) begin
          state_next.seated_flag   = 1'b0;
          state_next.long_sit_done = 1'b0;
          result.leave_event       = 1'b1;
        end
      end
      if (abs_inc > {1'b0, cfg.flush_delay_ticks} && !item.test_mode &&
          cfg.auto_flush_enable && state.flush_armed) begin
        state_next.flush_armed = 1'b0;
        result.flush_request   = 1'b1;
      end
      if (abs_inc > {1'b0, cfg.deodor_off_ticks}) begin
        state_next.deodor_on = 1'b0;
      end
      if (abs_inc > {1'b0, cfg.energy_delay_ticks}) begin
        if (cfg.energy_save_allowed) begin
          state_next.energy_req = 1'b1;
        end
        state_next.absence_count = cfg.energy_delay_ticks;
      end
    end

    result.seated              = state_next.seated_flag;
    result.deodor_enable       = state_next.deodor_on;
    result.deodor_armed        = state_next.deodor_ready;
    result.energy_save_request = state_next.energy_req;
    result.seat_history        = state_next.history_bits;
  end

endmodule

### src/seat_occupancy_qualifier.sv
// Top level of the seat occupancy qualifier: configuration registers, state, output skid.
// Depends on soq_pkg and soq_step.
//
// Each request is one 10 ms tick with the seat sensor level and the test-mode flag, and
// yields exactly one result. The block takes one request per clock while its skid register
// is empty: the state update is a single pass of counter increments and compares. The result
// is written to the output register or, while the consumer stalls, to a one-entry skid
// register. in_ready drops only while the skid register holds a result.
// Configuration writes are always taken (cfg_ready is tied high) and should be made while
// no request is in flight.
module seat_occupancy_qualifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  soq_pkg::soq_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output soq_pkg::soq_out_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [soq_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [soq_pkg::CfgDataWidth-1:0]     cfg_data
);
  import soq_pkg::*;

  soq_cfg_t   cfg;
  soq_state_t state;
  soq_state_t state_next;
  soq_out_t   result;
  soq_out_t   skid_data;
  logic       skid_valid;
  logic       in_accept;
  logic       out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  soq_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (in_data),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_flush_enable   <= 1'b0;
      cfg.energy_save_allowed <= 1'b0;
      cfg.on_debounce_ticks   <= OnDebounceReset;
      cfg.long_sit_ticks      <= LongSitReset;
      cfg.off_debounce_ticks  <= OffDebounceReset;
      cfg.flush_delay_ticks   <= FlushDelayReset;
      cfg.deodor_off_ticks    <= DeodorOffReset;
      cfg.energy_delay_ticks  <= EnergyDelayReset;
    end else if (cfg_valid) begin
      case (soq_cfg_index_t'(cfg_index))
        CFG_AUTO_FLUSH_ENABLE:   cfg.auto_flush_enable   <= cfg_data[0];
        CFG_ENERGY_SAVE_ALLOWED: cfg.energy_save_allowed <= cfg_data[0];
        CFG_ON_DEBOUNCE_TICKS:   cfg.on_debounce_ticks   <= cfg_data[9:0];
        CFG_LONG_SIT_TICKS:      cfg.long_sit_ticks      <= cfg_data[10:0];
        CFG_OFF_DEBOUNCE_TICKS:  cfg.off_debounce_ticks  <= cfg_data;
        CFG_FLUSH_DELAY_TICKS:   cfg.flush_delay_ticks   <= cfg_data;
        CFG_DEODOR_OFF_TICKS:    cfg.deodor_off_ticks    <= cfg_data;
        CFG_ENERGY_DELAY_TICKS:  cfg.energy_delay_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Output register control; the skid entry drains into the output register first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_accept) begin
        out_data <= result;
      end
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for seat_occupancy_qualifier: tick requests with random bursts,
// a stalling consumer and a per-tick predictor of the qualifier. Depends on soq_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import soq_pkg::*;

  localparam int unsigned MaxReports   = 10;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 175;
  localparam int unsigned RandomPhases = 8;
  localparam longint unsigned RunLimitCycles = 1500000;

  typedef enum int {RX_STEADY, RX_COIN, RX_THIRD, RX_MOSTLY} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  soq_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  soq_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_AUTO_FLUSH_ENABLE;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  // Predicted qualifier state and register copy.
  soq_cfg_t pred_cfg;
  int unsigned presence_cnt;
  int unsigned absence_cnt;
  bit seated_st;
  bit long_sit_st;
  bit flush_armed_st;
  bit deodor_on_st;
  bit deodor_ready_st;
  bit energy_req_st;
  logic [1:0] history_st;

  soq_out_t pending_results[$];
  soq_out_t oldest_result;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // Sender and consumer pacing.
  int unsigned burst_left = 0;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  int unsigned hold_order = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_cycle = 0;
  rx_mode_t rx_mode = RX_STEADY;

  seat_occupancy_qualifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reset_prediction();
    pred_cfg.auto_flush_enable   = 1'b0;
    pred_cfg.energy_save_allowed = 1'b0;
    pred_cfg.on_debounce_ticks   = OnDebounceReset;
    pred_cfg.long_sit_ticks      = LongSitReset;
    pred_cfg.off_debounce_ticks  = OffDebounceReset;
    pred_cfg.flush_delay_ticks   = FlushDelayReset;
    pred_cfg.deodor_off_ticks    = DeodorOffReset;
    pred_cfg.energy_delay_ticks  = EnergyDelayReset;
    presence_cnt    = 0;
    absence_cnt     = 0;
    seated_st       = 1'b0;
    long_sit_st     = 1'b0;
    flush_armed_st  = 1'b0;
    deodor_on_st    = 1'b0;
    deodor_ready_st = 1'b0;
    energy_req_st   = 1'b0;
    history_st      = '0;
  endfunction

  // Narrow registers keep only their low bits of the write data.
  function automatic void set_register(soq_cfg_index_t idx, logic [15:0] v);
    case (idx)
      CFG_AUTO_FLUSH_ENABLE:   pred_cfg.auto_flush_enable   = v[0];
      CFG_ENERGY_SAVE_ALLOWED: pred_cfg.energy_save_allowed = v[0];
      CFG_ON_DEBOUNCE_TICKS:   pred_cfg.on_debounce_ticks   = v[9:0];
      CFG_LONG_SIT_TICKS:      pred_cfg.long_sit_ticks      = v[10:0];
      CFG_OFF_DEBOUNCE_TICKS:  pred_cfg.off_debounce_ticks  = v;
      CFG_FLUSH_DELAY_TICKS:   pred_cfg.flush_delay_ticks   = v;
      CFG_DEODOR_OFF_TICKS:    pred_cfg.deodor_off_ticks    = v;
      default:                 pred_cfg.energy_delay_ticks  = v;
    endcase
  endfunction

  function automatic soq_out_t predict_tick(soq_in_t t);
    soq_out_t r;
    int unsigned nxt;
    r = '0;
    if (t.seat_present) begin
      nxt = presence_cnt + 1;
      absence_cnt = 0;
      if (nxt > pred_cfg.on_debounce_ticks) begin
        r.present_confirmed = 1'b1;
        deodor_on_st = 1'b1;
        energy_req_st = 1'b0;
        history_st |= HistOccupied;
        if (!seated_st) begin
          seated_st = 1'b1;
          r.sit_start = 1'b1;
        end
        if (nxt > pred_cfg.long_sit_ticks) begin
          nxt = pred_cfg.long_sit_ticks;
          if (!long_sit_st) begin
            long_sit_st = 1'b1;
            if (pred_cfg.auto_flush_enable) flush_armed_st = 1'b1;
          end
        end
      end
      presence_cnt = nxt & 32'h7FF;
    end else begin
      nxt = absence_cnt + 1;
      if (nxt > pred_cfg.off_debounce_ticks) begin
        r.absent_confirmed = 1'b1;
        presence_cnt = 0;
        deodor_ready_st = 1'b1;
        history_st |= HistLeft;
        if (seated_st) begin
          seated_st = 1'b0;
          long_sit_st = 1'b0;
          r.leave_event = 1'b1;
        end
      end
      if (nxt > pred_cfg.flush_delay_ticks && !t.test_mode &&
          pred_cfg.auto_flush_enable && flush_armed_st) begin
        flush_armed_st = 1'b0;
        r.flush_request = 1'b1;
      end
      if (nxt > pred_cfg.deodor_off_ticks) deodor_on_st = 1'b0;
      // The compare sees the full count; only the stored value is clamped.
      if (nxt > pred_cfg.energy_delay_ticks) begin
        if (pred_cfg.energy_save_allowed) energy_req_st = 1'b1;
        nxt = pred_cfg.energy_delay_ticks;
      end
      absence_cnt = nxt & 32'hFFFF;
    end
    r.seated              = seated_st;
    r.deodor_enable       = deodor_on_st;
    r.deodor_armed        = deodor_ready_st;
    r.energy_save_request = energy_req_st;
    r.seat_history        = history_st;
    return r;
  endfunction

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result %0d arrived with nothing pending: %p", results_seen, out_data);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("seated", oldest_result.seated, out_data.seated);
        check_field("present_confirmed", oldest_result.present_confirmed,
                    out_data.present_confirmed);
        check_field("sit_start", oldest_result.sit_start, out_data.sit_start);
        check_field("absent_confirmed", oldest_result.absent_confirmed,
                    out_data.absent_confirmed);
        check_field("leave_event", oldest_result.leave_event, out_data.leave_event);
        check_field("flush_request", oldest_result.flush_request, out_data.flush_request);
        check_field("deodor_enable", oldest_result.deodor_enable, out_data.deodor_enable);
        check_field("deodor_armed", oldest_result.deodor_armed, out_data.deodor_armed);
        check_field("energy_save_request", oldest_result.energy_save_request,
                    out_data.energy_save_request);
        check_field("seat_history", oldest_result.seat_history, out_data.seat_history);
      end
      results_seen++;
    end
  end

  // Consumer: a long hold-off when ordered, always ready in rx_fast runs, else a changing mode.
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_seen != hold_order) begin
      hold_seen = hold_order;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_fast) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(RX_STEADY, RX_MOSTLY));
        rx_phase_left = $urandom_range(16, 160);
      end
      rx_phase_left--;
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
        RX_THIRD:  out_ready <= (rx_cycle % 3 == 0);
        default:   out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    #(RunLimitCycles * 12);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_tick(input logic present, input logic test);
    soq_in_t t;
    int unsigned gap;
    t.seat_present = present;
    t.test_mode = test;
    if (!tx_fast && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_tick(t));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_run(input logic present, input logic test, input int unsigned n);
    repeat (n) send_tick(present, test);
  endtask

  // Stop offering requests and let every pending result come back.
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] afe, input logic [15:0] ese,
                             input logic [15:0] on_db, input logic [15:0] sit,
                             input logic [15:0] off_db, input logic [15:0] flush,
                             input logic [15:0] deo, input logic [15:0] energy);
    logic [15:0] vals [8];
    soq_cfg_index_t idx;
    vals = '{afe, ese, on_db, sit, off_db, flush, deo, energy};
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[idx];
      do @(posedge clk); while (!cfg_ready);
      set_register(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_run(1'b1, 1'b0, 11);
    send_run(1'b0, 1'b1, 3);
    drain_results();
  endtask

  task automatic test_leave_and_flush();
    load_config(1, 1, 2, 4, 1, 2, 3, 5);
    send_run(1'b1, 1'b0, 6);
    // Flush is held back while test mode is on, then fires once it drops.
    send_run(1'b0, 1'b1, 3);
    send_run(1'b0, 1'b0, 4);
    send_run(1'b1, 1'b1, 4);
    drain_results();
  endtask

  task automatic test_zero_thresholds();
    load_config(1, 1, 0, 1, 0, 0, 0, 1);
    send_run(1'b1, 1'b0, 2);
    send_tick(1'b0, 1'b1);
    send_run(1'b0, 1'b0, 2);
    send_tick(1'b1, 1'b1);
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, 2);
    drain_results();
  endtask

  task automatic test_long_sit_extreme();
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    load_config(1, 0, 20, 40, 0, 0, 65535, 65535);
    send_run(1'b1, 1'b0, 45);
    send_run(1'b0, 1'b0, 3);
    drain_results();
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  // The absence count reaches one past its clamp before it is held.
  task automatic test_absence_clamp_extreme();
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    load_config(1, 1, 0, 1, 40, 50, 55, 60);
    send_run(1'b1, 1'b0, 2);
    send_run(1'b0, 1'b0, 63);
    send_tick(1'b1, 1'b0);
    drain_results();
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  task automatic test_backpressure();
    load_config(1, 1, 3, 6, 2, 4, 8, 12);
    tx_fast = 1'b1;
    hold_len = 400;
    hold_order++;
    send_run(1'b1, 1'b0, 20);
    send_run(1'b0, 1'b0, 20);
    tx_fast = 1'b0;
    drain_results();
  endtask

  task automatic random_setting(input bit raw);
    if (raw) begin
      load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end else begin
      load_config(16'($urandom_range(0, 1)), 16'($urandom_range(0, 1)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(1, 16)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 20)),
                  16'($urandom_range(0, 30)), 16'($urandom_range(1, 40)));
    end
  endtask

  // Mostly runs of sitting and leaving of random length around the thresholds, some noise.
  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned run_len;
    logic run_test;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      random_setting(phase == RandomPhases / 2);
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 9) < 2) begin
          send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
          sent++;
        end else begin
          run_len = $urandom_range(1, 24);
          run_test = ($urandom_range(0, 3) == 0);
          repeat (run_len) send_tick(1'b1, run_test ^ ($urandom_range(0, 15) == 0));
          sent += run_len;
          run_len = $urandom_range(1, 48);
          run_test = ($urandom_range(0, 3) == 0);
          repeat (run_len) send_tick(1'b0, run_test ^ ($urandom_range(0, 15) == 0));
          sent += run_len;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    reset_prediction();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_leave_and_flush();
    test_zero_thresholds();
    test_long_sit_extreme();
    test_absence_clamp_extreme();
    test_backpressure();
    test_random_sequences();
    drain_results();
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
src/soq_pkg.sv
src/soq_step.sv
src/seat_occupancy_qualifier.sv
tb/testbench.sv
